// ----- hdl/hrbp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP request byte parser package
// Shared types, constants and the method recogniser for the request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbp_pkg;

    // Bound on the method token length; a token of this length or more is an error.
    localparam int MaxMethodLen = 8;
    // Width of the method length counter, which saturates at MaxMethodLen.
    localparam int LenW = $clog2(MaxMethodLen + 1);
    // Number of method bytes kept for comparison.
    localparam int MethodBytes = 8;
    localparam int MethodCharW = 8 * MethodBytes;

    // Character codes used by the parser.
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChQuery = 8'h3F;
    localparam logic [7:0] ChEquals = 8'h3D;
    localparam logic [7:0] ChAmp = 8'h26;
    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChLf = 8'h0A;

    // Parsing phases of one request.
    typedef enum logic [2:0] {
        PH_METHOD   = 3'd0,
        PH_RESOURCE = 3'd1,
        PH_KEY      = 3'd2,
        PH_VALUE    = 3'd3,
        PH_HEADER   = 3'd4,
        PH_BODY     = 3'd5
    } t_phase;

    // Label given to each byte.
    typedef enum logic [3:0] {
        CLS_METHOD      = 4'd0,
        CLS_METHOD_END  = 4'd1,
        CLS_RESOURCE    = 4'd2,
        CLS_QUERY_START = 4'd3,
        CLS_KEY         = 4'd4,
        CLS_KEY_END     = 4'd5,
        CLS_VALUE       = 4'd6,
        CLS_VALUE_END   = 4'd7,
        CLS_HEADER      = 4'd8,
        CLS_TERMINATOR  = 4'd9,
        CLS_BODY        = 4'd10
    } t_byte_class;

    // Recognised methods.
    typedef enum logic [2:0] {
        MTH_GET     = 3'd0,
        MTH_POST    = 3'd1,
        MTH_HEAD    = 3'd2,
        MTH_OPTIONS = 3'd3,
        MTH_PUT     = 3'd4,
        MTH_DELETE  = 3'd5,
        MTH_TRACE   = 3'd6,
        MTH_ERROR   = 3'd7
    } t_method;

    // Match the collected token against the known methods. The whole token must
    // match, so the length takes part in the comparison.
    function automatic t_method classify_method(
        input logic [MethodCharW-1:0] chars,
        input logic [LenW-1:0]        len
    );
        t_method code;
        code = MTH_ERROR;
        if (int'(len) < MaxMethodLen && int'(len) <= MethodBytes) begin
            if (int'(len) == 3 && chars == MethodCharW'(64'h474554)) begin
                code = MTH_GET;
            end else if (int'(len) == 4 && chars == MethodCharW'(64'h504F5354)) begin
                code = MTH_POST;
            end else if (int'(len) == 4 && chars == MethodCharW'(64'h48454144)) begin
                code = MTH_HEAD;
            end else if (int'(len) == 7 && chars == MethodCharW'(64'h4F5054494F4E53)) begin
                code = MTH_OPTIONS;
            end else if (int'(len) == 3 && chars == MethodCharW'(64'h505554)) begin
                code = MTH_PUT;
            end else if (int'(len) == 6 && chars == MethodCharW'(64'h44454C455445)) begin
                code = MTH_DELETE;
            end else if (int'(len) == 5 && chars == MethodCharW'(64'h5452414345)) begin
                code = MTH_TRACE;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/http_request_byte_parser.sv -----
// ----------------------------------------------------------------------------
// HTTP request byte parser
// Labels every byte of an HTTP request with its role in the request line,
// query string, headers or body, and reports the recognised method.
// ----------------------------------------------------------------------------
//
// The parser takes one request byte per clock cycle while its output is taken
// and returns one labelled byte for each; the label for a byte appears on the
// output in the cycle after its transfer is accepted and is held in an output
// register until taken. A new byte is accepted in every cycle in which that
// register is empty or is being emptied, so while the output is not stalled
// the sustained rate is one byte per cycle. Set the start flag on the first
// byte of each request; it clears the method, phase and terminator tracking
// before that byte is handled.
`default_nettype none

module http_request_byte_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Request byte stream.
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic       i_s_axis_tuser,  // [0] start_of_request
    // Labelled byte stream.
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,  // [7:0] byte_out
    output logic [9:0]      o_m_axis_tuser   // [3:0] byte_class, [6:4] method_code,
                                             // [7] method_done, [8] pair_done,
                                             // [9] key_unpaired
);

    // Parser state.
    hrbp_pkg::t_phase                  r_phase, n_phase;
    logic [hrbp_pkg::MethodCharW-1:0]  r_chars, n_chars;
    logic [hrbp_pkg::LenW-1:0]         r_len, n_len;
    hrbp_pkg::t_method                 r_method, n_method;
    logic [1:0]                        r_prog, n_prog;

    // Output register.
    logic                              r_out_valid;
    logic [7:0]                        r_out_byte;
    logic [9:0]                        r_out_user;

    // State as seen by the current byte, after a start-of-request clear.
    hrbp_pkg::t_phase                  e_phase;
    logic [hrbp_pkg::MethodCharW-1:0]  e_chars;
    logic [hrbp_pkg::LenW-1:0]         e_len;
    hrbp_pkg::t_method                 e_method;
    logic [1:0]                        e_prog;

    logic                              accept;
    logic [7:0]                        b;
    logic                              term_done;
    hrbp_pkg::t_byte_class             cls;
    logic                              mdone;
    logic                              pdone;
    logic                              unpaired;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign b = i_s_axis_tdata;

    // Clear the tracking state when a new request begins.
    always_comb begin
        if (i_s_axis_tuser) begin
            e_phase  = hrbp_pkg::PH_METHOD;
            e_chars  = '0;
            e_len    = '0;
            e_method = hrbp_pkg::MTH_ERROR;
            e_prog   = '0;
        end else begin
            e_phase  = r_phase;
            e_chars  = r_chars;
            e_len    = r_len;
            e_method = r_method;
            e_prog   = r_prog;
        end
    end

    // Search for CR LF CR LF in every byte before the body.
    always_comb begin
        term_done = 1'b0;
        n_prog    = e_prog;
        if (e_phase != hrbp_pkg::PH_BODY) begin
            if (b == (e_prog[0] ? hrbp_pkg::ChLf : hrbp_pkg::ChCr)) begin
                n_prog    = e_prog + 2'd1;
                term_done = (e_prog == 2'd3);
            end else begin
                n_prog = (b == hrbp_pkg::ChCr) ? 2'd1 : 2'd0;
            end
        end
    end

    // Next phase and method tracking.
    always_comb begin
        n_phase  = e_phase;
        n_chars  = e_chars;
        n_len    = e_len;
        n_method = e_method;
        if (e_phase != hrbp_pkg::PH_BODY) begin
            if (term_done) begin
                n_phase = hrbp_pkg::PH_BODY;
            end else begin
                case (e_phase)
                    hrbp_pkg::PH_METHOD: begin
                        if (b == hrbp_pkg::ChSpace) begin
                            n_method = hrbp_pkg::classify_method(e_chars, e_len);
                            n_phase  = hrbp_pkg::PH_RESOURCE;
                        end else begin
                            if (int'(e_len) < hrbp_pkg::MethodBytes) begin
                                n_chars = {e_chars[hrbp_pkg::MethodCharW-9:0], b};
                            end
                            if (int'(e_len) < hrbp_pkg::MaxMethodLen) begin
                                n_len = e_len + hrbp_pkg::LenW'(1);
                            end
                        end
                    end
                    hrbp_pkg::PH_RESOURCE: begin
                        if (b == hrbp_pkg::ChQuery) begin
                            n_phase = hrbp_pkg::PH_KEY;
                        end else if (b == hrbp_pkg::ChSpace) begin
                            n_phase = hrbp_pkg::PH_HEADER;
                        end
                    end
                    hrbp_pkg::PH_KEY: begin
                        if (b == hrbp_pkg::ChEquals) begin
                            n_phase = hrbp_pkg::PH_VALUE;
                        end else if (b == hrbp_pkg::ChSpace) begin
                            n_phase = hrbp_pkg::PH_HEADER;
                        end
                    end
                    hrbp_pkg::PH_VALUE: begin
                        if (b == hrbp_pkg::ChAmp) begin
                            n_phase = hrbp_pkg::PH_KEY;
                        end else if (b == hrbp_pkg::ChSpace) begin
                            n_phase = hrbp_pkg::PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = hrbp_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    // Byte label and event flags.
    always_comb begin
        cls      = hrbp_pkg::CLS_HEADER;
        mdone    = 1'b0;
        pdone    = 1'b0;
        unpaired = 1'b0;
        if (e_phase == hrbp_pkg::PH_BODY) begin
            cls = hrbp_pkg::CLS_BODY;
        end else if (term_done) begin
            cls = hrbp_pkg::CLS_TERMINATOR;
        end else begin
            case (e_phase)
                hrbp_pkg::PH_METHOD: begin
                    if (b == hrbp_pkg::ChSpace) begin
                        cls   = hrbp_pkg::CLS_METHOD_END;
                        mdone = 1'b1;
                    end else begin
                        cls = hrbp_pkg::CLS_METHOD;
                    end
                end
                hrbp_pkg::PH_RESOURCE: begin
                    if (b == hrbp_pkg::ChQuery) begin
                        cls = hrbp_pkg::CLS_QUERY_START;
                    end else if (b == hrbp_pkg::ChSpace) begin
                        cls = hrbp_pkg::CLS_HEADER;
                    end else begin
                        cls = hrbp_pkg::CLS_RESOURCE;
                    end
                end
                hrbp_pkg::PH_KEY: begin
                    if (b == hrbp_pkg::ChEquals) begin
                        cls = hrbp_pkg::CLS_KEY_END;
                    end else if (b == hrbp_pkg::ChSpace) begin
                        cls      = hrbp_pkg::CLS_KEY_END;
                        unpaired = 1'b1;
                    end else begin
                        cls = hrbp_pkg::CLS_KEY;
                    end
                end
                hrbp_pkg::PH_VALUE: begin
                    if (b == hrbp_pkg::ChAmp || b == hrbp_pkg::ChSpace) begin
                        cls   = hrbp_pkg::CLS_VALUE_END;
                        pdone = 1'b1;
                    end else begin
                        cls = hrbp_pkg::CLS_VALUE;
                    end
                end
                default: begin
                    cls = hrbp_pkg::CLS_HEADER;
                end
            endcase
        end
    end

    // State registers, updated on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrbp_pkg::PH_METHOD;
            r_chars  <= '0;
            r_len    <= '0;
            r_method <= hrbp_pkg::MTH_ERROR;
            r_prog   <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_chars  <= n_chars;
            r_len    <= n_len;
            r_method <= n_method;
            r_prog   <= n_prog;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded with each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte <= b;
            r_out_user <= {unpaired, pdone, mdone, n_method, cls};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ----- verif/tb_http_request_byte_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP request byte parser
// Streams directed requests, well-formed random requests, broken requests
// and byte noise into the parser with random gaps and output stalls. It
// labels every accepted byte with an independent parser model and checks
// each labelled byte that comes out against the oldest predicted label.
// ----------------------------------------------------------------------------

module tb_http_request_byte_parser;

    import hrbp_pkg::*;

    // One request byte as it travels on the input stream.
    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } req_byte_t;

    // One labelled byte as it travels on the output stream.
    typedef struct packed {
        logic [7:0]  byte_out;
        t_byte_class cls;
        t_method     method;
        logic        method_done;
        logic        pair_done;
        logic        key_unpaired;
    } byte_label_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;  // [7:0] data_byte
    logic       i_s_axis_tuser = 1'b0;   // [0] start_of_request
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;          // [7:0] byte_out
    logic [9:0] o_m_axis_tuser;          // [3:0] byte_class, [6:4] method_code,
                                         // [7] method_done, [8] pair_done,
                                         // [9] key_unpaired

    http_request_byte_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bytes still to be sent, and labels still to be received.
    req_byte_t   request_bytes [$];
    byte_label_t pending_labels [$];
    logic        next_start = 1'b0;

    int fault_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int ready_hold = 0;
    int ready_calm = 0;
    byte_label_t want_label;
    byte_label_t got_label;

    // Known method tokens, each beside its code.
    string   method_names [7] = '{"GET", "POST", "HEAD", "OPTIONS", "PUT", "DELETE", "TRACE"};
    t_method method_codes [7] = '{MTH_GET, MTH_POST, MTH_HEAD, MTH_OPTIONS, MTH_PUT,
                                  MTH_DELETE, MTH_TRACE};
    logic [7:0] special_bytes [6] = '{ChCr, ChLf, ChSpace, ChQuery, ChEquals, ChAmp};

    // Parser model state.
    t_phase     parse_phase = PH_METHOD;
    logic [7:0] token_q [$];
    int         token_len = 0;
    t_method    held_method = MTH_ERROR;
    logic [1:0] crlf_matched = 2'd0;

    function automatic void restart_request();
        parse_phase = PH_METHOD;
        token_q.delete();
        token_len = 0;
        held_method = MTH_ERROR;
        crlf_matched = 2'd0;
    endfunction

    // The whole token must equal a known name; long tokens are always errors.
    function automatic t_method method_verdict();
        t_method verdict;
        logic    same;
        verdict = MTH_ERROR;
        if (token_len < MaxMethodLen) begin
            for (int i = 0; i < 7; i++) begin
                if (method_names[i].len() == token_q.size()) begin
                    same = 1'b1;
                    for (int k = 0; k < token_q.size(); k++) begin
                        if (token_q[k] != method_names[i][k]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        verdict = method_codes[i];
                    end
                end
            end
        end
        return verdict;
    endfunction

    // Advance the model by one byte and return the label that byte should get.
    function automatic byte_label_t label_byte(logic [7:0] b, logic first);
        byte_label_t lab;
        logic [7:0]  want;
        logic        closed;
        if (first) begin
            restart_request();
        end
        lab = '{byte_out: b, cls: CLS_HEADER, method: MTH_ERROR,
                method_done: 1'b0, pair_done: 1'b0, key_unpaired: 1'b0};
        if (parse_phase == PH_BODY) begin
            lab.cls = CLS_BODY;
        end else begin
            // Track CR LF CR LF across every phase before the body.
            want = crlf_matched[0] ? ChLf : ChCr;
            closed = 1'b0;
            if (b == want) begin
                crlf_matched = crlf_matched + 2'd1;
                closed = (crlf_matched == 2'd0);
            end else begin
                crlf_matched = (b == ChCr) ? 2'd1 : 2'd0;
            end

            if (closed) begin
                lab.cls = CLS_TERMINATOR;
                parse_phase = PH_BODY;
            end else begin
                case (parse_phase)
                    PH_METHOD: begin
                        if (b == ChSpace) begin
                            held_method = method_verdict();
                            lab.cls = CLS_METHOD_END;
                            lab.method_done = 1'b1;
                            parse_phase = PH_RESOURCE;
                        end else begin
                            lab.cls = CLS_METHOD;
                            if (token_q.size() < MethodBytes) begin
                                token_q.insert(token_q.size(), b);
                            end
                            if (token_len < MaxMethodLen) begin
                                token_len++;
                            end
                        end
                    end
                    PH_RESOURCE: begin
                        if (b == ChQuery) begin
                            lab.cls = CLS_QUERY_START;
                            parse_phase = PH_KEY;
                        end else if (b == ChSpace) begin
                            lab.cls = CLS_HEADER;
                            parse_phase = PH_HEADER;
                        end else begin
                            lab.cls = CLS_RESOURCE;
                        end
                    end
                    PH_KEY: begin
                        if (b == ChEquals) begin
                            lab.cls = CLS_KEY_END;
                            parse_phase = PH_VALUE;
                        end else if (b == ChSpace) begin
                            lab.cls = CLS_KEY_END;
                            lab.key_unpaired = 1'b1;
                            parse_phase = PH_HEADER;
                        end else begin
                            lab.cls = CLS_KEY;
                        end
                    end
                    PH_VALUE: begin
                        if (b == ChAmp || b == ChSpace) begin
                            lab.cls = CLS_VALUE_END;
                            lab.pair_done = 1'b1;
                            parse_phase = (b == ChAmp) ? PH_KEY : PH_HEADER;
                        end else begin
                            lab.cls = CLS_VALUE;
                        end
                    end
                    default: begin
                        lab.cls = CLS_HEADER;
                        parse_phase = PH_HEADER;
                    end
                endcase
            end
        end
        lab.method = held_method;
        return lab;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch without any.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic string show_label(byte_label_t l);
        return $sformatf("byte %02h class %0d method %0d done m%b p%b k%b", l.byte_out,
                         l.cls, l.method, l.method_done, l.pair_done, l.key_unpaired);
    endfunction

    task automatic report_fault(string what);
        if (fault_count < 10) begin
            $display("[%0t] %s", $time, what);
        end
        fault_count++;
    endtask

    // Stimulus building: the start flag goes on the first byte queued after it is set.
    task automatic put_byte(logic [7:0] b);
        request_bytes.insert(request_bytes.size(), '{first: next_start, data: b});
        next_start = 1'b0;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endtask

    task automatic put_word(int n, string chars);
        repeat (n) begin
            put_byte(chars[$urandom_range(0, chars.len() - 1)]);
        end
    endtask

    task automatic put_crlf();
        put_byte(ChCr);
        put_byte(ChLf);
    endtask

    // A request with random content; some start without the flag, some are cut short.
    task automatic add_request();
        int    pick;
        int    mark;
        int    cut;
        string name;
        mark = request_bytes.size();
        next_start = ($urandom_range(0, 19) != 0);
        pick = $urandom_range(0, 11);
        if (pick < 7) begin
            put_text(method_names[pick]);
        end else begin
            case (pick)
                7: put_word($urandom_range(8, 12), "ABCDEGHILNOPSTU");
                8: ;
                9: begin
                    name = method_names[$urandom_range(0, 6)];
                    put_text(name.substr(0, name.len() - 2));
                end
                10: begin
                    put_text("GE");
                    put_byte(8'h00);
                    put_text("T");
                end
                default: put_word(7, "ACEHINOPST");
            endcase
        end
        put_byte(ChSpace);
        put_text("/");
        put_word($urandom_range(0, 6), "abcxyz019/._-%");
        if ($urandom_range(0, 2) != 0) begin
            put_byte(ChQuery);
            pick = $urandom_range(1, 3);
            for (int i = 0; i < pick; i++) begin
                if (i > 0) begin
                    put_byte(ChAmp);
                end
                put_word($urandom_range(1, 4), "abkqz1&");
                if ($urandom_range(0, 3) != 0) begin
                    put_byte(ChEquals);
                    put_word($urandom_range(0, 4), "v01=xy");
                end
            end
        end
        put_text(" HTTP/1.1");
        put_crlf();
        repeat ($urandom_range(0, 2)) begin
            put_text("Host: h");
            put_crlf();
        end
        put_crlf();
        repeat ($urandom_range(0, 6)) begin
            put_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, request_bytes.size() - mark);
            while (request_bytes.size() > mark + cut) begin
                void'(request_bytes.pop_back());
            end
        end
    endtask

    // Random bytes, rich in delimiters, with the start flag set at random.
    task automatic add_noise();
        repeat ($urandom_range(1, 15)) begin
            next_start = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1) == 0) begin
                put_byte(8'($urandom_range(0, 255)));
            end else begin
                put_byte(special_bytes[$urandom_range(0, 5)]);
            end
        end
    endtask

    // Input side: present queued bytes, hold each until its transfer completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_labels.insert(pending_labels.size(),
                                      label_byte(i_s_axis_tdata, i_s_axis_tuser));
            end
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (request_bytes.size() > 0) begin
                    i_s_axis_tdata <= request_bytes[0].data;
                    i_s_axis_tuser <= request_bytes[0].first;
                    i_s_axis_tvalid <= 1'b1;
                    void'(request_bytes.pop_front());
                    send_gap = idle_len(send_calm);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, and every transfer checked against the oldest label.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_label = '{byte_out: o_m_axis_tdata,
                              cls: t_byte_class'(o_m_axis_tuser[3:0]),
                              method: t_method'(o_m_axis_tuser[6:4]),
                              method_done: o_m_axis_tuser[7],
                              pair_done: o_m_axis_tuser[8],
                              key_unpaired: o_m_axis_tuser[9]};
                if (pending_labels.size() == 0) begin
                    report_fault({"unexpected output: ", show_label(got_label)});
                end else begin
                    want_label = pending_labels.pop_front();
                    if (got_label.byte_out !== want_label.byte_out
                            || got_label.cls !== want_label.cls
                            || got_label.method !== want_label.method
                            || got_label.method_done !== want_label.method_done
                            || got_label.pair_done !== want_label.pair_done
                            || got_label.key_unpaired !== want_label.key_unpaired) begin
                        report_fault({"mismatch: expected ", show_label(want_label),
                                      ", got ", show_label(got_label)});
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                ready_hold = idle_len(ready_calm);
            end
        end
    end

    initial begin
        // Bytes straight after reset with no start flag, then a stray zero and 0xFF
        // inside the method token.
        put_byte(8'h00);
        put_text("G");
        put_byte(8'hFF);
        put_byte(ChSpace);
        // Empty method, '&' inside a key, '=' inside a value, a finished pair
        // and a key that ends at a space without '='.
        next_start = 1'b1;
        put_byte(ChSpace);
        put_byte(ChQuery);
        put_byte(ChAmp);
        put_byte(ChEquals);
        put_byte(ChEquals);
        put_byte(ChAmp);
        put_byte(ChSpace);
        // Resource without a query, then the header terminator and a body byte.
        next_start = 1'b1;
        put_text("PUT x ");
        put_crlf();
        put_crlf();
        put_text("Z");
        // A zero byte inside the token does not end it.
        next_start = 1'b1;
        put_text("GE");
        put_byte(8'h00);
        put_text("T ");

        while (request_bytes.size() < 1775) begin
            if ($urandom_range(0, 4) != 0) begin
                add_request();
            end else begin
                add_noise();
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (i_rst_n);
        while (request_bytes.size() != 0 || i_s_axis_tvalid || pending_labels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("** http_request_byte_parser: PASSED **");
        end else begin
            $display("** http_request_byte_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("** http_request_byte_parser: FAILED **");
        $finish;
    end

endmodule
